[hw/rtl/led_effect_sequencer_defines.svh]
// Assertion macros for the LED effect sequencer.
// Used by the controller and datapath files; no other dependencies.
`ifndef LED_EFFECT_SEQUENCER_DEFINES_SVH
`define LED_EFFECT_SEQUENCER_DEFINES_SVH

// Same-cycle implication
`define LES_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/les_pkg.sv]
// Shared types, constants and the segment ROM of the LED effect sequencer.
// No dependencies.
package les_pkg;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_START  = 2'd1,
        CMD_STEADY = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    localparam logic [1:0] REG_LED    = 2'd0;
    localparam logic [1:0] REG_BUZZ   = 2'd1;
    localparam logic [1:0] REG_VIB    = 2'd2;
    localparam logic [1:0] REG_BRIGHT = 2'd3;

    localparam logic [7:0] BRIGHT_RST = 8'd64;
    localparam logic [2:0] FX_NONE    = 3'd0;
    localparam logic [2:0] FX_GRAD    = 3'd6;

    localparam int DUR_W  = 11;
    localparam int PROD_W = 19;
    localparam int HZ_W   = 12;
    localparam int CNT_W  = 5;

    typedef struct packed {
        logic [DUR_W-1:0] dur;
        logic [2:0]       from_rgb;
        logic [2:0]       to_rgb;
        logic [HZ_W-1:0]  hz;
        logic             vib;
    } t_seg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic fin;
        logic publish;
    } t_ctl;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_sts;

    function automatic t_seg seg_rom(input logic [4:0] a);
        case (a)
            5'd0:  return t_seg'{11'd500,  3'd2, 3'd6, 12'd1500, 1'b1};
            5'd1:  return t_seg'{11'd500,  3'd6, 3'd4, 12'd2200, 1'b0};
            5'd2:  return t_seg'{11'd500,  3'd4, 3'd6, 12'd2200, 1'b1};
            5'd3:  return t_seg'{11'd500,  3'd6, 3'd2, 12'd1500, 1'b0};
            5'd4:  return t_seg'{11'd120,  3'd1, 3'd1, 12'd400,  1'b1};
            5'd5:  return t_seg'{11'd120,  3'd0, 3'd0, 12'd0,    1'b0};
            5'd6:  return t_seg'{11'd120,  3'd1, 3'd1, 12'd400,  1'b1};
            5'd7:  return t_seg'{11'd120,  3'd0, 3'd0, 12'd0,    1'b0};
            5'd8:  return t_seg'{11'd120,  3'd1, 3'd1, 12'd400,  1'b1};
            5'd9:  return t_seg'{11'd120,  3'd0, 3'd0, 12'd0,    1'b0};
            5'd10: return t_seg'{11'd480,  3'd1, 3'd0, 12'd300,  1'b1};
            5'd11: return t_seg'{11'd120,  3'd6, 3'd6, 12'd2000, 1'b1};
            5'd12: return t_seg'{11'd120,  3'd0, 3'd0, 12'd0,    1'b0};
            5'd13: return t_seg'{11'd120,  3'd6, 3'd6, 12'd2000, 1'b0};
            5'd14: return t_seg'{11'd120,  3'd0, 3'd0, 12'd0,    1'b0};
            5'd15: return t_seg'{11'd120,  3'd6, 3'd6, 12'd2000, 1'b0};
            5'd16: return t_seg'{11'd120,  3'd0, 3'd0, 12'd0,    1'b0};
            5'd17: return t_seg'{11'd120,  3'd2, 3'd2, 12'd2500, 1'b1};
            5'd18: return t_seg'{11'd120,  3'd0, 3'd0, 12'd0,    1'b0};
            5'd19: return t_seg'{11'd120,  3'd2, 3'd2, 12'd2500, 1'b0};
            5'd20: return t_seg'{11'd120,  3'd0, 3'd0, 12'd0,    1'b0};
            5'd21: return t_seg'{11'd2000, 3'd2, 3'd4, 12'd0,    1'b0};
            5'd22: return t_seg'{11'd2000, 3'd4, 3'd2, 12'd0,    1'b0};
            default: return t_seg'{11'd1, 3'd0, 3'd0, 12'd0, 1'b0};
        endcase
    endfunction

    function automatic logic [4:0] fx_first(input logic [2:0] fx);
        case (fx)
            3'd2:    return 5'd2;
            3'd3:    return 5'd4;
            3'd4:    return 5'd11;
            3'd5:    return 5'd17;
            3'd6:    return 5'd21;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [2:0] fx_count(input logic [2:0] fx);
        case (fx)
            3'd1:    return 3'd2;
            3'd2:    return 3'd2;
            3'd3:    return 3'd7;
            3'd4:    return 3'd6;
            3'd5:    return 3'd4;
            3'd6:    return 3'd2;
            default: return 3'd0;
        endcase
    endfunction

endpackage

[hw/rtl/les_intf.sv]
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on nothing.
interface les_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic [2:0]  effect_id;
    logic [7:0]  color_r;
    logic [7:0]  color_g;
    logic [7:0]  color_b;
    modport source (output valid, command, now_ms, effect_id, color_r, color_g, color_b,
                    input ready);
    modport sink   (input valid, command, now_ms, effect_id, color_r, color_g, color_b,
                    output ready);
endinterface

interface les_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  led_r;
    logic [7:0]  led_g;
    logic [7:0]  led_b;
    logic        mono_led;
    logic [11:0] buzz_hz;
    logic        vibrate;
    logic        effect_active;
    modport source (output valid, led_r, led_g, led_b, mono_led, buzz_hz, vibrate,
                    effect_active, input ready);
    modport sink   (input valid, led_r, led_g, led_b, mono_led, buzz_hz, vibrate,
                    effect_active, output ready);
endinterface

interface les_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/led_effect_sequencer.sv]
// A tick of a running effect passes decode, 19 divider steps, finish and publish;
// every other item passes decode and publish only. Items are taken one at a time,
// and publish waits until the output register is free.
// A new item is taken while the previous result waits in the output register.
// Reset (synchronous, active low): no effect, dark, silent, all enables on,
// brightness 64.
module led_effect_sequencer #(
    parameter int TIME_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    les_in_if.sink    i_in,
    les_cfg_if.sink   i_cfg,
    les_out_if.source o_out
);
    import les_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    les_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_ctl      (w_ctl)
    );

    les_datapath #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_out   (o_out),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts)
    );

endmodule

[hw/rtl/les_ctrl.sv]
// Sequencing state machine of the LED effect sequencer.
// Depends on les_pkg and led_effect_sequencer_defines.svh.
`include "led_effect_sequencer_defines.svh"
module les_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  les_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output les_pkg::t_ctl o_ctl
);
    import les_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = i_sts.need_div ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (i_sts.div_last) n_state = ST_FIN;
            end
            ST_FIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_ctl          = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            ST_EVAL: o_ctl.eval     = 1'b1;
            ST_DIV:  o_ctl.div_step = 1'b1;
            ST_FIN:  o_ctl.fin      = 1'b1;
            ST_DONE: o_ctl.publish  = i_sts.out_free;
            default: o_ctl          = '0;
        endcase
    end

    `LES_ASSERT_NEXT(a_div_to_fin, i_clk, i_rst_n, (r_state == ST_DIV) && i_sts.div_last, r_state == ST_FIN, "divider end did not reach finish")
    `LES_ASSERT_NEXT(a_eval_path, i_clk, i_rst_n, (r_state == ST_EVAL) && !i_sts.need_div, r_state == ST_DONE, "eval without divide did not finish")
    `LES_ASSERT_NEXT(a_load_eval, i_clk, i_rst_n, o_ctl.load, r_state == ST_EVAL, "accepted item not evaluated")

endmodule

[hw/rtl/les_datapath.sv]
// State registers, segment lookup, serial divider and result buffer.
// Depends on les_pkg, les_intf and led_effect_sequencer_defines.svh.
`include "led_effect_sequencer_defines.svh"
module les_datapath #(
    parameter int TIME_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    les_in_if.sink        i_in,
    les_cfg_if.sink       i_cfg,
    les_out_if.source     o_out,
    input  les_pkg::t_ctl i_ctl,
    output les_pkg::t_sts o_sts
);
    import les_pkg::*;

    logic [1:0]            r_cmd;
    logic [TIME_WIDTH-1:0] r_now;
    logic [2:0]            r_fx;
    logic [23:0]           r_col;

    logic                  r_en_led;
    logic                  r_en_buzz;
    logic                  r_en_vib;
    logic [7:0]            r_bright;

    logic [2:0]            r_cur;
    logic [2:0]            r_idx;
    logic [TIME_WIDTH-1:0] r_start;
    logic                  r_entered;
    logic [23:0]           r_steady;
    logic [24:0]           r_shown;
    logic [HZ_W-1:0]       r_tone;
    logic                  r_vib;

    t_seg                  r_seg;
    logic [2:0]            r_count;
    logic                  r_adv;
    logic [DUR_W-1:0]      r_rem;
    logic [PROD_W-1:0]     r_dvd;
    logic [CNT_W-1:0]      r_cnt;

    logic                  r_out_valid;

    logic [2:0]            w_cnt;
    logic [2:0]            w_idx;
    t_seg                  w_seg;
    logic [TIME_WIDTH-1:0] w_el;
    logic                  w_el_done;
    logic [DUR_W-1:0]      w_elc;
    logic [PROD_W-1:0]     w_prod;
    logic [DUR_W:0]        w_trial;
    logic                  w_fit;
    logic [7:0]            w_q;
    logic [23:0]           w_lerp;
    logic [2:0]            w_nidx;

    function automatic logic [24:0] paint(input logic [23:0] c, input logic en);
        return {|c, c & {24{en}}};
    endfunction

    function automatic logic [7:0] chan(input logic lit0, input logic lit1,
                                        input logic [7:0] b, input logic [7:0] q);
        if (lit0 == lit1) return lit0 ? b : 8'd0;
        else if (lit1)    return q;
        else              return b - q;
    endfunction

    assign w_cnt     = fx_count(r_cur);
    assign w_idx     = (r_idx >= w_cnt) ? 3'd0 : r_idx;
    assign w_seg     = seg_rom(fx_first(r_cur) + {2'b00, w_idx});
    assign w_el      = r_now - r_start;
    assign w_el_done = w_el >= TIME_WIDTH'(w_seg.dur);
    assign w_elc     = w_el_done ? w_seg.dur : w_el[DUR_W-1:0];
    assign w_prod    = PROD_W'(r_bright) * PROD_W'(w_elc);
    assign w_trial   = {r_rem, r_dvd[PROD_W-1]};
    assign w_fit     = w_trial >= {1'b0, r_seg.dur};
    assign w_q       = r_dvd[7:0];
    assign w_lerp    = {chan(r_seg.from_rgb[2], r_seg.to_rgb[2], r_bright, w_q),
                        chan(r_seg.from_rgb[1], r_seg.to_rgb[1], r_bright, w_q),
                        chan(r_seg.from_rgb[0], r_seg.to_rgb[0], r_bright, w_q)};
    assign w_nidx    = r_idx + 3'd1;

    assign o_sts.need_div = (r_cmd == CMD_TICK) && (r_cur != FX_NONE) && (w_cnt != 3'd0);
    assign o_sts.div_last = r_cnt == CNT_W'(PROD_W - 1);
    assign o_sts.out_free = !r_out_valid || o_out.ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_in.command;
            r_now <= TIME_WIDTH'(i_in.now_ms);
            r_fx  <= i_in.effect_id;
            r_col <= {i_in.color_r, i_in.color_g, i_in.color_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_led  <= 1'b1;
            r_en_buzz <= 1'b1;
            r_en_vib  <= 1'b1;
            r_bright  <= BRIGHT_RST;
            r_cur     <= FX_NONE;
            r_idx     <= 3'd0;
            r_start   <= '0;
            r_entered <= 1'b0;
            r_steady  <= '0;
            r_shown   <= '0;
            r_tone    <= '0;
            r_vib     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_LED: begin
                        r_en_led <= i_cfg.data[0];
                        if (!i_cfg.data[0] && r_cur == FX_NONE) begin
                            r_shown <= paint(r_steady, 1'b0);
                        end
                    end
                    REG_BUZZ:   r_en_buzz <= i_cfg.data[0];
                    REG_VIB:    r_en_vib  <= i_cfg.data[0];
                    REG_BRIGHT: r_bright  <= i_cfg.data;
                    default:    r_bright  <= r_bright;
                endcase
            end
            if (i_ctl.eval) begin
                case (r_cmd)
                    CMD_TICK: begin
                        if (r_cur != FX_NONE) begin
                            if (w_cnt == 3'd0) begin
                                r_cur   <= FX_NONE;
                                r_tone  <= '0;
                                r_vib   <= 1'b0;
                                r_shown <= paint(r_steady, r_en_led);
                            end else begin
                                r_idx <= w_idx;
                                if (!r_entered) begin
                                    r_entered <= 1'b1;
                                    r_tone    <= r_en_buzz ? w_seg.hz : '0;
                                    r_vib     <= r_en_vib & w_seg.vib;
                                end
                            end
                        end
                    end
                    CMD_START: begin
                        if (r_fx == FX_NONE) begin
                            r_cur   <= FX_NONE;
                            r_tone  <= '0;
                            r_vib   <= 1'b0;
                            r_shown <= paint(r_steady, r_en_led);
                        end else begin
                            r_cur     <= r_fx;
                            r_idx     <= 3'd0;
                            r_start   <= r_now;
                            r_entered <= 1'b0;
                        end
                    end
                    CMD_STEADY: begin
                        r_steady <= r_col;
                        if (r_cur == FX_NONE) r_shown <= paint(r_col, r_en_led);
                    end
                    default: r_steady <= r_steady;
                endcase
            end
            if (i_ctl.fin) begin
                if (r_adv) begin
                    r_start   <= r_now;
                    r_entered <= 1'b0;
                end
                if (r_adv && (w_nidx >= r_count) && (r_cur != FX_GRAD)) begin
                    r_idx   <= w_nidx;
                    r_cur   <= FX_NONE;
                    r_tone  <= '0;
                    r_vib   <= 1'b0;
                    r_shown <= paint(r_steady, r_en_led);
                end else begin
                    r_shown <= paint(w_lerp, r_en_led);
                    if (r_adv) begin
                        r_idx <= (w_nidx >= r_count) ? 3'd0 : w_nidx;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.eval) begin
            r_seg   <= w_seg;
            r_count <= w_cnt;
            r_adv   <= w_el_done;
            r_dvd   <= w_prod;
            r_rem   <= '0;
            r_cnt   <= '0;
        end else if (i_ctl.div_step) begin
            r_rem <= w_fit ? DUR_W'(w_trial - {1'b0, r_seg.dur}) : w_trial[DUR_W-1:0];
            r_dvd <= {r_dvd[PROD_W-2:0], w_fit};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.publish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.publish) begin
            o_out.led_r         <= r_shown[23:16] & {8{r_en_led}};
            o_out.led_g         <= r_shown[15:8] & {8{r_en_led}};
            o_out.led_b         <= r_shown[7:0] & {8{r_en_led}};
            o_out.mono_led      <= r_shown[24];
            o_out.buzz_hz       <= r_tone;
            o_out.vibrate       <= r_vib;
            o_out.effect_active <= r_cur != FX_NONE;
        end
    end

    assign o_out.valid = r_out_valid;

    `LES_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, r_cur == FX_NONE,
        (r_tone == '0) && !r_vib, "idle block drives tone or vibration")
    `LES_ASSERT_NOW(a_quot_range, i_clk, i_rst_n, i_ctl.fin,
        r_dvd <= PROD_W'(r_bright), "interpolation step exceeds brightness")
    `LES_ASSERT_NOW(a_rem_range, i_clk, i_rst_n, i_ctl.div_step,
        r_rem < r_seg.dur, "divider remainder out of range")

endmodule

[tb/les_tb_intf.sv]
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces are taken from the RTL file les_intf.sv.
// This file holds the monitor record type shared by the testbench; depends on les_pkg.
package les_tb_pkg;
    import les_pkg::*;

    typedef struct packed {
        logic [7:0]  led_r;
        logic [7:0]  led_g;
        logic [7:0]  led_b;
        logic        mono_led;
        logic [11:0] buzz_hz;
        logic        vibrate;
        logic        effect_active;
    } t_led_out;
endpackage

[tb/led_effect_sequencer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of led_effect_sequencer: a directed table, then random ticks
// and starts checked against a behavioral model. Depends on les_pkg, les_tb_pkg, les_intf.
module led_effect_sequencer_tb;
    import les_pkg::*;
    import les_tb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] now;
        logic [2:0]  fx;
        logic [23:0] rgb;
        bit          known;
        t_led_out    res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    les_in_if  in_ch();
    les_out_if out_ch();
    les_cfg_if cfg_ch();

    led_effect_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (out_ch.source)
    );

    // model state
    logic        m_led, m_buzz, m_vib;
    logic [7:0]  m_bright;
    logic [2:0]  m_fx, m_seg;
    logic [31:0] m_seg_start;
    logic        m_entered;
    logic [23:0] m_steady;
    logic [24:0] m_shown;
    logic [11:0] m_tone;
    logic        m_vibl;

    t_led_out pending_leds[$];
    int  errors = 0;
    int  cycles = 0;
    int  send_idle = 0;
    int  recv_stall = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        t_led_out got;
        t_led_out want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.led_r, out_ch.led_g, out_ch.led_b, out_ch.mono_led,
                    out_ch.buzz_hz, out_ch.vibrate, out_ch.effect_active};
            if (pending_leds.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_leds.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    function automatic void paint_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [7:0] m;
        m = m_led ? 8'hFF : 8'h00;
        m_shown = {((r | g | b) != 0), r & m, g & m, b & m};
    endfunction

    function automatic void stop_fx();
        m_fx = FX_NONE;
        m_tone = '0;
        m_vibl = 1'b0;
        paint_color(m_steady[23:16], m_steady[15:8], m_steady[7:0]);
    endfunction

    function automatic logic [7:0] ramp(logic lit0, logic lit1, int el, int dur);
        int c0;
        int c1;
        c0 = lit0 ? int'(m_bright) : 0;
        c1 = lit1 ? int'(m_bright) : 0;
        return 8'((c0 + (c1 - c0) * el / dur) & 255);
    endfunction

    function automatic void advance_tick(logic [31:0] now);
        logic [2:0]  cnt;
        t_seg        s;
        logic [31:0] el;
        int          elc;
        cnt = fx_count(m_fx);
        if (cnt == 0) begin
            stop_fx();
            return;
        end
        if (m_seg >= cnt) m_seg = 0;
        s = seg_rom(fx_first(m_fx) + 5'(m_seg));
        if (!m_entered) begin
            m_entered = 1'b1;
            m_tone = (m_buzz && s.hz != 0) ? s.hz : 12'd0;
            m_vibl = m_vib && s.vib;
        end
        el = now - m_seg_start;
        elc = (el > 32'(s.dur)) ? int'(s.dur) : int'(el);
        paint_color(ramp(s.from_rgb[2], s.to_rgb[2], elc, int'(s.dur)),
                    ramp(s.from_rgb[1], s.to_rgb[1], elc, int'(s.dur)),
                    ramp(s.from_rgb[0], s.to_rgb[0], elc, int'(s.dur)));
        if (el >= 32'(s.dur)) begin
            m_seg = m_seg + 1;
            m_seg_start = now;
            m_entered = 1'b0;
            if (m_seg >= cnt) begin
                if (m_fx == FX_GRAD) m_seg = 0;
                else stop_fx();
            end
        end
    endfunction

    function automatic t_led_out predict_leds(logic [1:0] cmd, logic [31:0] now,
                                              logic [2:0] fx, logic [23:0] rgb);
        logic [7:0] m;
        case (t_cmd'(cmd))
            CMD_TICK: if (m_fx != FX_NONE) advance_tick(now);
            CMD_START: begin
                if (fx == FX_NONE) stop_fx();
                else begin
                    m_fx = fx;
                    m_seg = 0;
                    m_seg_start = now;
                    m_entered = 1'b0;
                end
            end
            CMD_STEADY: begin
                m_steady = rgb;
                if (m_fx == FX_NONE) paint_color(rgb[23:16], rgb[15:8], rgb[7:0]);
            end
            default: ;
        endcase
        m = m_led ? 8'hFF : 8'h00;
        return '{m_shown[23:16] & m, m_shown[15:8] & m, m_shown[7:0] & m, m_shown[24],
                 m_tone, m_vibl, m_fx != FX_NONE};
    endfunction

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_leds.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_LED: begin
                m_led = val[0];
                if (!m_led && m_fx == FX_NONE)
                    paint_color(m_steady[23:16], m_steady[15:8], m_steady[7:0]);
            end
            REG_BUZZ:   m_buzz = val[0];
            REG_VIB:    m_vib = val[0];
            REG_BRIGHT: m_bright = val;
            default: ;
        endcase
    endtask

    task automatic send_item(t_row row);
        t_led_out want;
        while ($urandom_range(0, 99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= row.cmd;
        in_ch.now_ms    <= row.now;
        in_ch.effect_id <= row.fx;
        {in_ch.color_r, in_ch.color_g, in_ch.color_b} <= row.rgb;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        want = predict_leds(row.cmd, row.now, row.fx, row.rgb);
        if (row.known && want !== row.res) begin
            $display("%0t: table row expected %h model %h", $time, row.res, want);
            errors++;
        end
        pending_leds.push_back(want);
    endtask

    task automatic run_effect(logic [31:0] t0, logic [2:0] fx, int steps);
        t_row row;
        logic [31:0] t;
        t = t0;
        row = '{CMD_START, t, fx, 24'($urandom), 0, '0};
        send_item(row);
        for (int k = 0; k < steps; k++) begin
            t = t + ((($urandom_range(0, 9)) == 0) ? $urandom : $urandom_range(0, 260));
            case ($urandom_range(0, 19))
                0: row = '{CMD_STEADY, t, 3'($urandom), 24'($urandom), 0, '0};
                1: row = '{CMD_START, t, 3'($urandom), 24'($urandom), 0, '0};
                2: row = '{CMD_NOP, t, 3'($urandom), 24'($urandom), 0, '0};
                default: row = '{CMD_TICK, t, 3'($urandom), 24'($urandom), 0, '0};
            endcase
            send_item(row);
        end
    endtask

    t_row dir_rows[$];

    initial begin
        int sent;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = '0;
        in_ch.now_ms = '0;
        in_ch.effect_id = '0;
        in_ch.color_r = '0;
        in_ch.color_g = '0;
        in_ch.color_b = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b1;
        m_led = 1; m_buzz = 1; m_vib = 1; m_bright = BRIGHT_RST;
        m_fx = FX_NONE; m_seg = 0; m_seg_start = 0; m_entered = 0;
        m_steady = 0; m_shown = 0; m_tone = 0; m_vibl = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_rows = '{
            '{CMD_TICK,   32'd0,          3'd0, 24'h0,      1, '0},
            '{CMD_STEADY, 32'd0,          3'd0, 24'hFFFFFF, 1,
              '{8'hFF, 8'hFF, 8'hFF, 1'b1, 12'd0, 1'b0, 1'b0}},
            '{CMD_NOP,    32'hFFFFFFFF,   3'd7, 24'h0,      1,
              '{8'hFF, 8'hFF, 8'hFF, 1'b1, 12'd0, 1'b0, 1'b0}},
            '{CMD_START,  32'hFFFFFF00,   3'd1, 24'h0,      0, '0},
            '{CMD_TICK,   32'hFFFFFF00,   3'd0, 24'h0,      0, '0},
            '{CMD_TICK,   32'h000000F4,   3'd0, 24'h0,      0, '0},
            '{CMD_STEADY, 32'h000000F4,   3'd0, 24'h123456, 0, '0},
            '{CMD_TICK,   32'h00000300,   3'd0, 24'h0,      0, '0},
            '{CMD_TICK,   32'h00000500,   3'd0, 24'h0,      0, '0},
            '{CMD_START,  32'd10,         3'd7, 24'h0,      0, '0},
            '{CMD_TICK,   32'd20,         3'd0, 24'h0,      1,
              '{8'h12, 8'h34, 8'h56, 1'b1, 12'd0, 1'b0, 1'b0}},
            '{CMD_START,  32'd0,          3'd6, 24'h0,      0, '0},
            '{CMD_TICK,   32'd1000,       3'd0, 24'h0,      0, '0},
            '{CMD_TICK,   32'd2000,       3'd0, 24'h0,      0, '0},
            '{CMD_TICK,   32'd5000,       3'd0, 24'h0,      0, '0},
            '{CMD_START,  32'd0,          3'd0, 24'h0,      1,
              '{8'h12, 8'h34, 8'h56, 1'b1, 12'd0, 1'b0, 1'b0}},
            '{CMD_START,  32'd0,          3'd2, 24'h0,      0, '0},
            '{CMD_START,  32'd0,          3'd3, 24'h0,      0, '0},
            '{CMD_TICK,   32'd60,         3'd0, 24'h0,      0, '0},
            '{CMD_START,  32'd0,          3'd4, 24'h0,      0, '0},
            '{CMD_TICK,   32'd130,        3'd0, 24'h0,      0, '0},
            '{CMD_START,  32'd0,          3'd5, 24'h0,      0, '0},
            '{CMD_TICK,   32'd200,        3'd0, 24'h0,      0, '0},
            '{CMD_START,  32'd0,          3'd0, 24'h0,      0, '0}
        };
        foreach (dir_rows[i]) send_item(dir_rows[i]);

        write_reg(REG_LED, 8'd0);
        write_reg(REG_BRIGHT, 8'd255);
        run_effect(32'd0, 3'd1, 6);
        write_reg(REG_BUZZ, 8'd0);
        write_reg(REG_VIB, 8'd0);
        write_reg(REG_LED, 8'd1);
        run_effect(32'hFFFFFF80, 3'd3, 10);
        write_reg(REG_BRIGHT, 8'd0);
        write_reg(REG_BUZZ, 8'd1);
        write_reg(REG_VIB, 8'd1);
        run_effect(32'd0, 3'd6, 6);

        sent = 0;
        for (int ph = 0; sent < 1600; ph++) begin
            case (ph % 5)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 78; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 78; end
                3: begin send_idle = 11; recv_stall = 11; end
                default: begin send_idle = 0; recv_stall = 0; wait_drained(); end
            endcase
            if (ph % 4 == 0) begin
                write_reg(REG_BRIGHT, (ph % 8 == 0) ? 8'd255 : 8'($urandom));
                write_reg(2'($urandom_range(0, 2)), 8'($urandom));
            end
            for (int e = 0; e < 4; e++) begin
                int n;
                n = $urandom_range(5, 30);
                run_effect($urandom, 3'($urandom_range(1, 7)), n);
                sent += n + 1;
            end
        end

        recv_stall = 0;
        wait_drained();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
